[hw/rtl/lpe_pkg.sv]
package lpe_pkg;

    // Number format of the point and of the polynomial terms.
    localparam int FRAC_BITS  = 30;
    localparam int X_W        = 32;
    localparam int MAG_W      = X_W - 1;
    localparam int MAX_ORDER  = 63;
    localparam int ORD_W      = 6;
    localparam int SLOPE_W    = 44;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 80;

    // Recurrence numerator n*(2m - prev) + m and its operands.
    localparam int OPND_W     = X_W + 2;
    localparam int SPROD_W    = OPND_W + ORD_W + 1;
    localparam int NUM_W      = 39;
    localparam int LA_W       = NUM_W - 1;

    // Small-divisor divider: one byte of quotient per cycle.
    localparam int RADIX_W    = 8;
    localparam int SDIV_W     = 40;
    localparam int SDIVR_W    = ORD_W + 1;
    localparam int SWRK_W     = SDIVR_W + RADIX_W;
    localparam int CHUNKS     = SDIV_W / RADIX_W;
    localparam int SCNT_W     = $clog2(CHUNKS);

    // Slope divider: one quotient bit per cycle.
    localparam int PRE_W      = SLOPE_W - FRAC_BITS;
    localparam int SHB_W      = MAG_W + PRE_W;
    localparam int LCNT_W     = $clog2(SLOPE_W);

    localparam logic signed [X_W-1:0] ONE_Q = X_W'(64'd1 << FRAC_BITS);
    localparam logic [2*MAG_W:0] HALF_LSB   = (2*MAG_W+1)'(64'd1 << (FRAC_BITS - 1));
    localparam logic [SLOPE_W:0] LIM_POS    = (SLOPE_W+1)'((64'd1 << (SLOPE_W - 1)) - 64'd1);
    localparam logic [SLOPE_W:0] LIM_NEG    = (SLOPE_W+1)'(64'd1 << (SLOPE_W - 1));

endpackage

[hw/rtl/lpe_mul.sv]
// Rounded fixed-point multiplier: the product magnitude is registered and then
// rounded half away from zero and shifted down by the fraction width.
module lpe_mul
    import lpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  start,
    input  logic signed [X_W-1:0] a,
    input  logic signed [X_W-1:0] b,
    output logic signed [X_W-1:0] prod
);

    logic [MAG_W-1:0]   mag_a;
    logic [MAG_W-1:0]   mag_b;
    logic [2*MAG_W-1:0] prod_reg;
    logic               neg_reg;
    logic [2*MAG_W:0]   rnd;
    logic [MAG_W-1:0]   qmag;

    assign mag_a = a[X_W-1] ? MAG_W'(-a) : MAG_W'(a);
    assign mag_b = b[X_W-1] ? MAG_W'(-b) : MAG_W'(b);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= mag_a * mag_b;
            neg_reg  <= a[X_W-1] ^ b[X_W-1];
        end
    end

    assign rnd  = {1'b0, prod_reg} + HALF_LSB;
    assign qmag = rnd[FRAC_BITS +: MAG_W];
    assign prod = neg_reg ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});

endmodule

[hw/rtl/lpe_sdiv.sv]
// Divider for small divisors: retires one byte of quotient per cycle with
// eight conditional subtracts on a narrow partial remainder.
module lpe_sdiv
    import lpe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SDIV_W-1:0]  dividend,
    input  logic [SDIVR_W-1:0] divisor,
    output logic               done,
    output logic [SDIV_W-1:0]  quot
);

    logic [SDIV_W-1:0]  sh_reg;
    logic [SDIV_W-1:0]  q_reg;
    logic [SDIVR_W-1:0] rem_reg;
    logic [SDIVR_W-1:0] d_reg;
    logic [SCNT_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [SWRK_W-1:0]  wrk;
    logic [RADIX_W-1:0] qbyte;

    always_comb
    begin
        wrk   = {rem_reg, sh_reg[SDIV_W-1 -: RADIX_W]};
        qbyte = '0;
        for (int i = RADIX_W - 1; i >= 0; i--)
        begin
            if (wrk >= (SWRK_W'(d_reg) << i))
            begin
                wrk      = wrk - (SWRK_W'(d_reg) << i);
                qbyte[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SCNT_W'(CHUNKS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - SCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            q_reg   <= '0;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_reg << RADIX_W;
            q_reg   <= {q_reg[SDIV_W-RADIX_W-1:0], qbyte};
            rem_reg <= wrk[SDIVR_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[hw/rtl/lpe_ldiv.sv]
// Slope divider: round((a << FRAC_BITS) / b) with saturation. Quotients that
// would reach past the slope width are caught up front by one compare, so
// only the low SLOPE_W quotient bits are worked out, one per cycle.
module lpe_ldiv
    import lpe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [LA_W-1:0]    dividend,
    input  logic [MAG_W-1:0]   divisor,
    input  logic               neg,
    output logic               done,
    output logic [SLOPE_W-1:0] quot
);

    logic [MAG_W-1:0]   rem_reg;
    logic [SLOPE_W-1:0] q_reg;
    logic [SLOPE_W-1:0] sh_reg;
    logic [MAG_W-1:0]   b_reg;
    logic [LCNT_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               sat_reg;
    logic               neg_reg;
    logic [MAG_W:0]     trial;
    logic               fits;
    logic [MAG_W-1:0]   rem_step;
    logic               rnd_up;
    logic [SLOPE_W:0]   q_rnd;
    logic [SLOPE_W:0]   limit;

    assign trial    = {rem_reg, sh_reg[SLOPE_W-1]};
    assign fits     = trial >= {1'b0, b_reg};
    assign rem_step = fits ? MAG_W'(trial - {1'b0, b_reg}) : trial[MAG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= LCNT_W'(SLOPE_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - LCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sat_reg <= SHB_W'(dividend) >= {divisor, {PRE_W{1'b0}}};
            rem_reg <= MAG_W'(dividend >> PRE_W);
            sh_reg  <= {dividend[PRE_W-1:0], {FRAC_BITS{1'b0}}};
            q_reg   <= '0;
            b_reg   <= divisor;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            q_reg   <= {q_reg[SLOPE_W-2:0], fits};
            sh_reg  <= sh_reg << 1;
        end
    end

    // Round half up on the final remainder, then clip to the signed limit.
    assign rnd_up = {rem_reg, 1'b0} >= {1'b0, b_reg};
    assign q_rnd  = {1'b0, q_reg} + (SLOPE_W+1)'(rnd_up);
    assign limit  = neg_reg ? LIM_NEG : LIM_POS;
    assign quot   = (sat_reg || (q_rnd > limit)) ? limit[SLOPE_W-1:0] : q_rnd[SLOPE_W-1:0];
    assign done   = done_reg;

endmodule

[hw/rtl/legendre_poly_eval.sv]
// Legendre polynomial evaluator. Each input beat carries an order N (0..63)
// and a point x in signed Q1.30; x is clamped to [-1, 1] first. The result
// beat carries P_N(x) in Q1.30, the slope dP_N/dx in Q13.30 (saturated to
// 44 bits) and, in tuser, a singular flag that is set when x*x rounds to one
// and N is at least 2; the slope then reads zero. P_N comes from the Bonnet
// recurrence (n+1) P_{n+1} = (2n+1) x P_n - n P_{n-1}, and the slope from
// N*(x*P_N - P_{N-1})/(x*x - 1). Every product is rounded half away from
// zero, each recurrence term is rounded and clamped to [-1, 1]. The block
// takes one beat at a time: tready is high only while it is idle. For N
// of 2 and above, each recurrence step runs the shared 31x31 multiplier
// once and a byte-per-cycle divider (five passes) for the division by
// n+1, and the slope division at the end retires one quotient bit per
// cycle. At an endpoint the slope division is skipped. The finished
// result sits in an output register, so the next beat is taken while
// it waits for the downstream side.
module legendre_poly_eval
    import lpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [5:0] order, [37:6] point, [39:38] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [31:0] value, [75:32] slope, [79:76] zero
    output logic                  m_axis_tuser   // [0] singular
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_SQR   = 10'b00_0000_0010,
        ST_SQW   = 10'b00_0000_0100,
        ST_ISSUE = 10'b00_0000_1000,
        ST_MULW  = 10'b00_0001_0000,
        ST_COMB  = 10'b00_0010_0000,
        ST_GO    = 10'b00_0100_0000,
        ST_SDIV  = 10'b00_1000_0000,
        ST_LDIV  = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ORD_W-1:0]           ord_reg, ord_next;
    logic [ORD_W-1:0]           n_reg, n_next;
    logic signed [X_W-1:0]      x_reg, x_next;
    logic signed [X_W-1:0]      prev_reg, prev_next;
    logic signed [X_W-1:0]      cur_reg, cur_next;
    logic signed [X_W-1:0]      m_reg, m_next;
    logic signed [NUM_W-1:0]    num_reg, num_next;
    logic [MAG_W-1:0]           dmag_reg, dmag_next;
    logic signed [SLOPE_W-1:0]  slope_reg, slope_next;
    logic                       sing_reg, sing_next;

    logic                       out_valid_reg;
    logic [X_W-1:0]             out_value_reg;
    logic [SLOPE_W-1:0]         out_slope_reg;
    logic                       out_sing_reg;
    logic                       out_load;

    // Input decode and clamping.
    logic [ORD_W-1:0]           in_order;
    logic signed [X_W-1:0]      in_point;
    logic [ORD_W-1:0]           ord_in;
    logic signed [X_W-1:0]      x_in;

    // Shared multiplier.
    logic                       mul_start;
    logic signed [X_W-1:0]      mul_b;
    logic signed [X_W-1:0]      mul_prod;

    // Numerator datapath.
    logic                       fin;
    logic signed [OPND_W-1:0]   opnd;
    logic signed [ORD_W:0]      factor;
    logic signed [SPROD_W-1:0]  sprod;
    logic signed [X_W-1:0]      addend;
    logic                       num_neg;
    logic [NUM_W-1:0]           num_abs;
    logic [LA_W-1:0]            num_mag;

    // Dividers.
    logic [SDIVR_W-1:0]         sdiv_d;
    logic                       sdiv_start;
    logic [SDIV_W-1:0]          sdiv_dividend;
    logic                       sdiv_done;
    logic [SDIV_W-1:0]          sdiv_quot;
    logic signed [X_W-1:0]      step_mag;
    logic signed [X_W-1:0]      step_val;
    logic                       ldiv_start;
    logic                       ldiv_neg;
    logic                       ldiv_done;
    logic [SLOPE_W-1:0]         ldiv_quot;
    logic signed [SLOPE_W-1:0]  slope_res;

    assign in_order = s_axis_tdata[ORD_W-1:0];
    assign in_point = signed'(s_axis_tdata[ORD_W +: X_W]);
    assign ord_in   = (in_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : in_order;
    assign x_in     = (in_point > ONE_Q)  ? ONE_Q :
                      (in_point < -ONE_Q) ? -ONE_Q : in_point;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // The multiplier always takes x on one side; the other side is x for the
    // x*x term and the current polynomial term otherwise.
    assign mul_start = (state_reg == ST_SQR) || (state_reg == ST_ISSUE);
    assign mul_b     = (state_reg == ST_SQR) ? x_reg : cur_reg;

    lpe_mul u_mul (
        .clk   (clk),
        .start (mul_start),
        .a     (x_reg),
        .b     (mul_b),
        .prod  (mul_prod)
    );

    // With m = round(x*P_n), a recurrence step needs n*(2m - P_{n-1}) + m,
    // which equals (2n+1)*m - n*P_{n-1}. Once n has reached N the same unit
    // forms N*(m - P_{N-1}), the slope numerator.
    assign fin    = (n_reg == ord_reg);
    assign opnd   = fin ? (OPND_W'(m_reg) - OPND_W'(prev_reg))
                        : ((OPND_W'(m_reg) <<< 1) - OPND_W'(prev_reg));
    assign factor = signed'({1'b0, n_reg});
    assign sprod  = factor * opnd;
    assign addend = fin ? '0 : m_reg;

    assign num_neg = num_reg[NUM_W-1];
    assign num_abs = num_neg ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign num_mag = num_abs[LA_W-1:0];

    // Division by n+1, rounded half away from zero by adding half the
    // divisor to the magnitude.
    assign sdiv_d        = SDIVR_W'({1'b0, n_reg}) + SDIVR_W'(1);
    assign sdiv_start    = (state_reg == ST_GO) && !fin;
    assign sdiv_dividend = SDIV_W'(num_mag) + SDIV_W'(sdiv_d >> 1);

    lpe_sdiv u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sdiv_start),
        .dividend (sdiv_dividend),
        .divisor  (sdiv_d),
        .done     (sdiv_done),
        .quot     (sdiv_quot)
    );

    assign step_mag = (sdiv_quot > SDIV_W'(ONE_Q)) ? ONE_Q : signed'(sdiv_quot[X_W-1:0]);
    assign step_val = num_neg ? -step_mag : step_mag;

    // x*x - 1 is never positive, so the quotient is negated exactly when the
    // numerator is not negative.
    assign ldiv_start = (state_reg == ST_GO) && fin && (dmag_reg != '0);
    assign ldiv_neg   = !num_neg;

    lpe_ldiv u_ldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ldiv_start),
        .dividend (num_mag),
        .divisor  (dmag_reg),
        .neg      (ldiv_neg),
        .done     (ldiv_done),
        .quot     (ldiv_quot)
    );

    assign slope_res = ldiv_neg ? -signed'(ldiv_quot) : signed'(ldiv_quot);

    always_comb
    begin
        state_next = state_reg;
        ord_next   = ord_reg;
        n_next     = n_reg;
        x_next     = x_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        m_next     = m_reg;
        num_next   = num_reg;
        dmag_next  = dmag_reg;
        slope_next = slope_reg;
        sing_next  = sing_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ord_next   = ord_in;
                    x_next     = x_in;
                    prev_next  = ONE_Q;
                    n_next     = ORD_W'(1);
                    sing_next  = 1'b0;
                    slope_next = '0;
                    cur_next   = x_in;
                    if (ord_in == '0)
                    begin
                        cur_next   = ONE_Q;
                        state_next = ST_DONE;
                    end
                    else if (ord_in == ORD_W'(1))
                    begin
                        slope_next = SLOPE_W'(ONE_Q);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SQR;
                    end
                end
            end
            ST_SQR:
            begin
                state_next = ST_SQW;
            end
            ST_SQW:
            begin
                dmag_next  = MAG_W'(ONE_Q - mul_prod);
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                state_next = ST_MULW;
            end
            ST_MULW:
            begin
                m_next     = mul_prod;
                state_next = ST_COMB;
            end
            ST_COMB:
            begin
                num_next   = NUM_W'(sprod) + NUM_W'(addend);
                state_next = ST_GO;
            end
            ST_GO:
            begin
                if (!fin)
                begin
                    state_next = ST_SDIV;
                end
                else if (dmag_reg == '0)
                begin
                    sing_next  = 1'b1;
                    slope_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LDIV;
                end
            end
            ST_SDIV:
            begin
                if (sdiv_done)
                begin
                    prev_next  = cur_reg;
                    cur_next   = step_val;
                    n_next     = n_reg + ORD_W'(1);
                    state_next = ST_ISSUE;
                end
            end
            ST_LDIV:
            begin
                if (ldiv_done)
                begin
                    slope_next = slope_res;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ord_reg       <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ord_reg   <= ord_next;
            n_reg     <= n_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        m_reg     <= m_next;
        num_reg   <= num_next;
        dmag_reg  <= dmag_next;
        slope_reg <= slope_next;
        sing_reg  <= sing_next;
        if (out_load)
        begin
            out_value_reg <= cur_reg;
            out_slope_reg <= slope_reg;
            out_sing_reg  <= sing_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - X_W - SLOPE_W){1'b0}}, out_slope_reg, out_value_reg};
    assign m_axis_tuser  = out_sing_reg;

endmodule

[hw/rtl/lpe_chk.sv]
// Port-level checks for the Legendre evaluator.
module lpe_chk
    import lpe_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    logic signed [X_W-1:0] chk_value;

    assign chk_value = signed'(m_axis_tdata[X_W-1:0]);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // The block works on one item at a time, so it is busy right after a beat.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after a beat");

    // A singular point reports a zero slope.
    a_singular_slope: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[X_W +: SLOPE_W] == '0)
        else $error("slope not zero on a singular result");

    // Every recurrence term is clamped, so the value stays within [-1, 1].
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (chk_value <= ONE_Q) && (chk_value >= -ONE_Q))
        else $error("value outside [-1, 1]");

endmodule

bind legendre_poly_eval lpe_chk u_lpe_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[sim/tb_legendre_poly_eval.sv]
module tb_legendre_poly_eval
    import lpe_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // One result beat as the block reports it.
    typedef struct packed {
        logic [X_W-1:0]     value;
        logic [SLOPE_W-1:0] slope;
        logic               singular;
    } poly_answer_t;

    // Holds the answers still owed by the block, in issue order, and works
    // each one out from the order and point of the accepted input beat.
    class legendre_ledger;
        poly_answer_t owed_q[$];
        int           fail_count;
        int           queries;
        int           answers;
        int           singular_hits;
        int           saturated_hits;
        int           top_order_hits;

        function new();
            fail_count     = 0;
            queries        = 0;
            answers        = 0;
            singular_hits  = 0;
            saturated_hits = 0;
            top_order_hits = 0;
        endfunction

        task report(string msg);
            fail_count++;
            if (fail_count <= 200)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        function longint clamp_unit(longint v);
            longint unit;
            unit = 64'sd1 <<< FRAC_BITS;
            if (v > unit)
                return unit;
            if (v < -unit)
                return -unit;
            return v;
        endfunction

        // Fixed-point product, exact in 128 bits, rounded half away from zero.
        function longint mul_round(longint a, longint b);
            logic [63:0]  ma;
            logic [63:0]  mb;
            logic [127:0] p;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            p  = {64'd0, ma} * {64'd0, mb};
            p  = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
        endfunction

        function longint div_round(longint num, longint den);
            longint m;
            m = (((num < 0) ? -num : num) + den / 2) / den;
            return (num < 0) ? -m : m;
        endfunction

        function poly_answer_t eval_legendre(logic [ORD_W-1:0] ord, logic [X_W-1:0] pt);
            poly_answer_t res;
            longint       unit;
            longint       x;
            longint       prev;
            longint       cur;
            longint       nxt;
            longint       slope;
            longint       den;
            longint       num;
            int           n_ord;
            int           n;
            bit           neg;
            logic [63:0]  mag_num;
            logic [63:0]  mag_den;
            logic [63:0]  lim;
            logic [127:0] dividend;
            logic [127:0] quo;
            logic [127:0] rem;

            unit  = 64'sd1 <<< FRAC_BITS;
            n_ord = ord;
            if (n_ord > MAX_ORDER)
                n_ord = MAX_ORDER;
            x     = clamp_unit(longint'($signed(pt)));
            slope = 0;
            res.singular = 1'b0;

            if (n_ord == 0)
                cur = unit;
            else if (n_ord == 1)
            begin
                cur   = x;
                slope = unit;
            end
            else
            begin
                // Bonnet recurrence; each new term is rounded and clamped.
                prev = unit;
                cur  = x;
                for (n = 1; n < n_ord; n++)
                begin
                    nxt  = longint'(2 * n + 1) * mul_round(x, cur) - longint'(n) * prev;
                    nxt  = clamp_unit(div_round(nxt, longint'(n + 1)));
                    prev = cur;
                    cur  = nxt;
                end
                den = mul_round(x, x) - unit;
                if (den == 0)
                    res.singular = 1'b1;
                else
                begin
                    num      = longint'(n_ord) * (mul_round(x, cur) - prev);
                    neg      = (num < 0) != (den < 0);
                    mag_num  = (num < 0) ? -num : num;
                    mag_den  = (den < 0) ? -den : den;
                    lim      = neg ? 64'(LIM_NEG) : 64'(LIM_POS);
                    dividend = {64'd0, mag_num} << FRAC_BITS;
                    quo      = dividend / {64'd0, mag_den};
                    rem      = dividend % {64'd0, mag_den};
                    if (quo > {64'd0, lim})
                        quo = {64'd0, lim};
                    else
                    begin
                        // Round half up on the magnitude, then saturate.
                        if ((rem << 1) >= {64'd0, mag_den})
                            quo = quo + 1;
                        if (quo > {64'd0, lim})
                            quo = {64'd0, lim};
                    end
                    slope = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
                end
            end
            res.value = cur[X_W-1:0];
            res.slope = slope[SLOPE_W-1:0];
            return res;
        endfunction

        task note_query(logic [ORD_W-1:0] ord, logic [X_W-1:0] pt);
            poly_answer_t exp_ans;
            exp_ans = eval_legendre(ord, pt);
            owed_q.push_back(exp_ans);
            queries++;
            if (ord == MAX_ORDER)
                top_order_hits++;
        endtask

        task check_answer(logic [X_W-1:0] value, logic [SLOPE_W-1:0] slope, logic singular);
            poly_answer_t exp_ans;
            answers++;
            if (owed_q.size() == 0)
            begin
                report($sformatf("result beat with nothing pending: value %0d slope %0d sing %0b",
                                 $signed(value), $signed(slope), singular));
                return;
            end
            exp_ans = owed_q.pop_front();
            if (exp_ans.singular)
                singular_hits++;
            if (!exp_ans.singular && (exp_ans.slope == LIM_POS[SLOPE_W-1:0] ||
                                      exp_ans.slope == LIM_NEG[SLOPE_W-1:0]))
                saturated_hits++;
            if (value !== exp_ans.value || slope !== exp_ans.slope ||
                singular !== exp_ans.singular)
                report($sformatf("answer %0d: value %0d/%0d slope %0d/%0d sing %0b/%0b (got/exp)",
                                 answers, $signed(value), $signed(exp_ans.value),
                                 $signed(slope), $signed(exp_ans.slope),
                                 singular, exp_ans.singular));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [5:0] order, [37:6] point, [39:38] zero
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [31:0] value, [75:32] slope, [79:76] zero
    logic                  m_axis_tuser;   // [0] singular

    legendre_ledger ledger;

    // Percentages of cycles in which the sender holds back a beat and the
    // receiver drops tready; the main sequence changes them per phase.
    int send_idle_pct;
    int recv_stall_pct;

    legendre_poly_eval u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop. The slowest legal run (every beat at order 63, plus stalls)
    // is under 20 ms; this allows five times that.
    initial
    begin
        #100_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Every input beat the block takes is turned into an expected answer at
    // the same edge, so the expectation is always queued before the result.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            ledger.note_query(s_axis_tdata[ORD_W-1:0], s_axis_tdata[ORD_W+X_W-1:ORD_W]);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_answer(m_axis_tdata[X_W-1:0], m_axis_tdata[X_W+SLOPE_W-1:X_W],
                                m_axis_tuser);
    end

    // Downstream side: tready is redrawn on every falling edge so that
    // stalls land on any cycle of the block's work, including while the
    // finished result waits in the output register.
    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Presents one beat and holds it until the block takes it. With no
    // sender idling, tvalid simply stays high from one beat to the next.
    task automatic send_query(input logic [ORD_W-1:0] ord, input logic [X_W-1:0] pt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - X_W - ORD_W){1'b0}}, pt, ord};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random point: the full 32-bit space (so out-of-range values get
    // clamped and every bit toggles), the legal interval, the region close
    // to either endpoint where the slope blows up, the endpoints themselves,
    // and tiny magnitudes around zero.
    function automatic logic [X_W-1:0] pick_point();
        int     kind;
        longint unit;
        longint p;
        kind = $urandom_range(99);
        unit = 64'sd1 <<< FRAC_BITS;
        if (kind < 15)
            return $urandom();
        if (kind < 60)
            p = longint'($urandom_range(32'h8000_0000)) - unit;
        else if (kind < 80)
            p = unit - longint'($urandom_range(4095));
        else if (kind < 88)
            p = unit;
        else
            p = longint'($urandom_range(65535));
        if (kind >= 60 && $urandom_range(1))
            p = -p;
        return p[X_W-1:0];
    endfunction

    // Long recurrences are slow, so most random beats use low orders and
    // only a share goes to the very top of the range.
    function automatic logic [ORD_W-1:0] pick_order();
        int kind;
        kind = $urandom_range(99);
        if (kind < 55)
            return ORD_W'($urandom_range(15));
        if (kind < 85)
            return ORD_W'($urandom_range(MAX_ORDER));
        return ORD_W'($urandom_range(MAX_ORDER, MAX_ORDER - 7));
    endfunction

    initial
    begin
        int              ph;
        int              i;
        int              waited;
        int              idle_tbl[4];
        int              stall_tbl[4];
        logic [X_W-1:0]  unit;
        logic [ORD_W-1:0] d_ord[$];
        logic [X_W-1:0]  d_pt[$];

        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        idle_tbl       = '{0, 59, 0, 36};
        stall_tbl      = '{0, 0, 59, 36};
        unit           = ONE_Q;
        ledger         = new();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats: orders 0, 1 and 2 at zero and the top order one LSB
        // to either side of it, at both endpoints and beyond them (clamped back to
        // the endpoints), just inside the endpoints where the slope saturates,
        // and a few ordinary mid-range points.
        d_ord = '{6'd0, 6'd0, 6'd0, 6'd1, 6'd1, 6'd1, 6'd2, 6'd2, 6'd2,
                  6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd2,
                  6'd40, 6'd3, 6'd63, 6'd63, 6'd17, 6'd5, 6'd62, 6'd31};
        d_pt  = '{32'd0, unit, 32'h8000_0000, 32'd0, -unit, 32'h7FFF_FFFF,
                  unit, -unit, 32'd0,
                  unit, -unit, 32'h7FFF_FFFF, 32'h8000_0000, unit - 32'd1,
                  -(unit - 32'd1), unit - 32'd2, unit - 32'd1,
                  unit >> 1, -(unit / 3), 32'd1, -32'sd1, 32'h4000_0001,
                  unit + 32'd1000, 32'hC000_0000, 32'h1234_5678};
        for (i = 0; i < d_ord.size(); i++)
            send_query(d_ord[i], d_pt[i]);

        // Random beats in four traffic phases: free flowing, sender gaps,
        // receiver back-pressure, and both at once.
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_tbl[ph];
            recv_stall_pct = stall_tbl[ph];
            for (i = 0; i < 338; i++)
                send_query(pick_order(), pick_point());
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for the answers still owed, up to a bound.
        waited = 0;
        while (ledger.owed_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (ledger.owed_q.size() != 0)
            ledger.report($sformatf("%0d answers never came out", ledger.owed_q.size()));

        $display("Evaluated %0d orders/points (%0d at the top order); %0d answers checked.",
                 ledger.queries, ledger.top_order_hits, ledger.answers);
        $display("Endpoint singular answers: %0d, saturated slopes: %0d, mismatches: %0d.",
                 ledger.singular_hits, ledger.saturated_hits, ledger.fail_count);
        if (ledger.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
